// ===== hw/rtl/pcrd_pkg.sv =====
// Shared types and constants for the pinhole camera ray direction block.
package pcrd_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int CFG_W      = 16;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int COMP_W     = 32;
  localparam int LEAD_W     = 5;
  localparam int MAG_W      = 24;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SSQ_W      = SQ_W + 2;
  localparam int ROOT_W     = SSQ_W / 2;
  localparam int OUT_W      = 16;
  localparam int OUT_FRAC   = 15;
  localparam int NQ_W       = OUT_FRAC + 2;
  localparam int NNUM_W     = MAG_W + OUT_FRAC + 1;

  // leading one of the largest magnitude lands on this bit after normalizing
  localparam logic [LEAD_W-1:0] NORM_LEAD = LEAD_W'(MAG_W - 1);

  localparam logic signed [CFG_W-1:0] CORNER_X_RST = -16'sd4096;
  localparam logic signed [CFG_W-1:0] CORNER_Y_RST = -16'sd4096;
  localparam logic signed [CFG_W-1:0] CORNER_Z_RST = 16'sd4096;
  localparam logic [CFG_W-1:0]        SPAN_W_RST   = 16'd8192;
  localparam logic [CFG_W-1:0]        SPAN_H_RST   = 16'd8192;
  localparam logic [SIZE_W-1:0]       IMAGE_W_RST  = 13'd640;
  localparam logic [SIZE_W-1:0]       IMAGE_H_RST  = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_X = 3'd0,
    REG_CORNER_Y = 3'd1,
    REG_CORNER_Z = 3'd2,
    REG_SPAN_W   = 3'd3,
    REG_SPAN_H   = 3'd4,
    REG_IMAGE_W  = 3'd5,
    REG_IMAGE_H  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
    logic                    zero_vector;
  } ray_out_t;

endpackage

// ===== hw/rtl/pcrd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
module pcrd_div #(
  parameter int LANES = 1,
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int QUO_W = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]       num_i,
  input  logic [LANES-1:0][DEN_W-1:0]       den_i,
  output logic                              valid_o,
  output logic [LANES-1:0][QUO_W-1:0]       quo_o
);

  // num must stay below den << QUO_W
  localparam int RW = DEN_W + QUO_W;

  logic [LANES-1:0][RW-1:0]    rem_q [QUO_W-1];
  logic [LANES-1:0][DEN_W-1:0] den_q [QUO_W-1];
  logic [LANES-1:0][QUO_W-1:0] quo_q [QUO_W];
  logic                        vld_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic [LANES-1:0][RW-1:0]    rem_in;
    logic [LANES-1:0][DEN_W-1:0] den_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in;
    logic                        vld_in;
    logic [LANES-1:0][RW-1:0]    trial;
    logic [LANES-1:0][RW-1:0]    rem_nx;
    logic [LANES-1:0][QUO_W-1:0] quo_nx;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = RW'(num_i[l]);
        end
        den_in = den_i;
        quo_in = '0;
        vld_in = valid_i;
      end
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = RW'(den_in[l]) << SH;
        if (rem_in[l] >= trial[l]) begin
          rem_nx[l] = rem_in[l] - trial[l];
          quo_nx[l] = quo_in[l] | (QUO_W'(1) << SH);
        end else begin
          rem_nx[l] = rem_in[l];
          quo_nx[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_nx;
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_nx;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];

endmodule

// ===== hw/rtl/pcrd_sqrt.sv =====
// Pipelined integer square root (floor), one root bit per stage, with sideband.
module pcrd_sqrt #(
  parameter int R_W    = 25,
  parameter int SIDE_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*R_W-1:0]    rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [R_W-1:0]      root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int IN_W = 2 * R_W;

  logic [IN_W-1:0]   rem_q  [R_W-1];
  logic [R_W-1:0]    root_q [R_W];
  logic [SIDE_W-1:0] side_q [R_W];
  logic              vld_q  [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int B = R_W - 1 - k;
    logic [IN_W-1:0]   rem_in;
    logic [R_W-1:0]    root_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [IN_W-1:0]   trial;
    logic [IN_W-1:0]   rem_nx;
    logic [R_W-1:0]    root_nx;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (root + 2^B)^2 - root^2
    always_comb begin
      trial = (IN_W'(root_in) << (B + 1)) + (IN_W'(1) << (2 * B));
      if (rem_in >= trial) begin
        rem_nx  = rem_in - trial;
        root_nx = root_in | (R_W'(1) << B);
      end else begin
        rem_nx  = rem_in;
        root_nx = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_nx;
        side_q[k] <= side_in;
      end
    end

    if (k < R_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_nx;
        end
      end
    end
  end

  assign valid_o = vld_q[R_W-1];
  assign root_o  = root_q[R_W-1];
  assign side_o  = side_q[R_W-1];

endmodule

// ===== hw/rtl/pinhole_camera_ray_direction_top.sv =====
// Top level: pinhole camera primary ray direction pipeline.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one pixel coordinate
// pair per beat; output channel (out_valid_o/out_ready_i/out_data_o) gives one
// unit ray direction in Q1.15 per input, in order, plus a zero vector flag.
// Configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i)
// writes the seven camera registers; it is always ready. The user must
// write only while no pixel is in flight; the block itself does not
// enforce it. Unknown indexes are dropped. Throughput: one pixel per cycle
// while the receiver does not stall the output. The path runs through the
// span divider (29 stages), the square root (25 stages) and the normalizing
// divider (17 stages) plus the surrounding registers.
// Reset clears every valid bit and loads the registers with the default
// camera (640x480 image). When the receiver stalls, the last stage holds
// in the output register; the pipeline keeps taking input while it has
// bubbles to close up and stops, losing nothing, once the beat at its end
// has nowhere to go.
module pinhole_camera_ray_direction_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  pcrd_pkg::pix_in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output pcrd_pkg::ray_out_t                   out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pcrd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pcrd_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int PB     = pcrd_pkg::PIXEL_BITS;
  localparam int CW     = pcrd_pkg::CFG_W;
  localparam int SW     = pcrd_pkg::SIZE_W;
  localparam int PRODW  = CW + PB + 1;
  localparam int NUMW   = PRODW + 1;
  localparam int DENW   = SW + 1;
  localparam int TQW    = NUMW - 1;
  localparam int SUMW   = (TQW + 2 > 34) ? TQW + 2 : 34;
  localparam int CMPW   = pcrd_pkg::COMP_W;
  localparam int LW     = pcrd_pkg::LEAD_W;
  localparam int MW     = pcrd_pkg::MAG_W;
  localparam int QW     = pcrd_pkg::SQ_W;
  localparam int SSW    = pcrd_pkg::SSQ_W;
  localparam int RW     = pcrd_pkg::ROOT_W;
  localparam int NQW    = pcrd_pkg::NQ_W;
  localparam int NNW    = pcrd_pkg::NNUM_W;
  localparam int OW     = pcrd_pkg::OUT_W;
  localparam int SIDEW  = 3 * MW + 4;

  // ---------------- configuration registers
  logic signed [CW-1:0] corner_x_q, corner_y_q, corner_z_q;
  logic [CW-1:0]        span_w_q, span_h_q;
  logic [SW-1:0]        image_w_q, image_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_x_q <= pcrd_pkg::CORNER_X_RST;
      corner_y_q <= pcrd_pkg::CORNER_Y_RST;
      corner_z_q <= pcrd_pkg::CORNER_Z_RST;
      span_w_q   <= pcrd_pkg::SPAN_W_RST;
      span_h_q   <= pcrd_pkg::SPAN_H_RST;
      image_w_q  <= pcrd_pkg::IMAGE_W_RST;
      image_h_q  <= pcrd_pkg::IMAGE_H_RST;
    end else if (cfg_valid_i) begin
      case (pcrd_pkg::cfg_reg_e'(cfg_index_i))
        pcrd_pkg::REG_CORNER_X: corner_x_q <= cfg_data_i;
        pcrd_pkg::REG_CORNER_Y: corner_y_q <= cfg_data_i;
        pcrd_pkg::REG_CORNER_Z: corner_z_q <= cfg_data_i;
        pcrd_pkg::REG_SPAN_W:   span_w_q   <= cfg_data_i;
        pcrd_pkg::REG_SPAN_H:   span_h_q   <= cfg_data_i;
        pcrd_pkg::REG_IMAGE_W:  image_w_q  <= cfg_data_i[SW-1:0];
        pcrd_pkg::REG_IMAGE_H:  image_h_q  <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // zero image size acts as one
  logic [SW-1:0] size_x, size_y;
  assign size_x = (image_w_q == '0) ? SW'(1) : image_w_q;
  assign size_y = (image_h_q == '0) ? SW'(1) : image_h_q;

  // ---------------- pipeline advance
  logic en;
  logic v_last;
  logic out_valid_q;
  pcrd_pkg::ray_out_t out_data_q;

  assign en         = !out_valid_q || out_ready_i || !v_last;
  assign in_ready_o = en;

  // S1: span * (2p + 1)
  logic             s1_vld_q;
  logic [PRODW-1:0] prod_x_q, prod_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= PRODW'(span_w_q) * PRODW'({in_data_i.pixel_x, 1'b1});
      prod_y_q <= PRODW'(span_h_q) * PRODW'({in_data_i.pixel_y, 1'b1});
    end
  end

  // S2: add half divisor for rounding
  logic            s2_vld_q;
  logic [NUMW-1:0] num_x_q, num_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_x_q <= NUMW'(prod_x_q) + NUMW'(size_x);
      num_y_q <= NUMW'(prod_y_q) + NUMW'(size_y);
    end
  end

  // span divider: t = num / (2 * size)
  logic [1:0][NUMW-1:0] sdiv_num;
  logic [1:0][DENW-1:0] sdiv_den;
  logic [1:0][TQW-1:0]  sdiv_quo;
  logic                 sdiv_vld;

  assign sdiv_num[0] = num_x_q;
  assign sdiv_num[1] = num_y_q;
  assign sdiv_den[0] = {size_x, 1'b0};
  assign sdiv_den[1] = {size_y, 1'b0};

  pcrd_div #(
    .LANES (2),
    .NUM_W (NUMW),
    .DEN_W (DENW),
    .QUO_W (TQW)
  ) u_span_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .num_i   (sdiv_num),
    .den_i   (sdiv_den),
    .valid_o (sdiv_vld),
    .quo_o   (sdiv_quo)
  );

  // S3: corner + t, saturated to 32 bits
  logic signed [SUMW-1:0] sum_x, sum_y;
  logic signed [CMPW-1:0] sat_x, sat_y;

  always_comb begin
    sum_x = SUMW'($signed({2'b00, sdiv_quo[0]})) + SUMW'(corner_x_q);
    sum_y = SUMW'($signed({2'b00, sdiv_quo[1]})) + SUMW'(corner_y_q);
    if (sum_x[SUMW-1:CMPW-1] == '0 || sum_x[SUMW-1:CMPW-1] == '1) begin
      sat_x = sum_x[CMPW-1:0];
    end else begin
      sat_x = sum_x[SUMW-1] ? {1'b1, {(CMPW-1){1'b0}}} : {1'b0, {(CMPW-1){1'b1}}};
    end
    if (sum_y[SUMW-1:CMPW-1] == '0 || sum_y[SUMW-1:CMPW-1] == '1) begin
      sat_y = sum_y[CMPW-1:0];
    end else begin
      sat_y = sum_y[SUMW-1] ? {1'b1, {(CMPW-1){1'b0}}} : {1'b0, {(CMPW-1){1'b1}}};
    end
  end

  logic                   s3_vld_q;
  logic signed [CMPW-1:0] comp_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= sdiv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      comp_q[0] <= sat_x;
      comp_q[1] <= sat_y;
      comp_q[2] <= CMPW'(corner_z_q);
    end
  end

  // S4: sign and magnitude
  logic            s4_vld_q;
  logic [CMPW-1:0] mag4_q [3];
  logic [2:0]      neg4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg4_q[i] <= comp_q[i][CMPW-1];
        mag4_q[i] <= comp_q[i][CMPW-1] ? CMPW'(-comp_q[i]) : CMPW'(comp_q[i]);
      end
    end
  end

  // S5: largest magnitude
  logic [CMPW-1:0] mmax;
  always_comb begin
    mmax = mag4_q[0];
    if (mag4_q[1] > mmax) mmax = mag4_q[1];
    if (mag4_q[2] > mmax) mmax = mag4_q[2];
  end

  logic            s5_vld_q;
  logic [CMPW-1:0] mag5_q [3];
  logic [CMPW-1:0] mmax_q;
  logic [2:0]      neg5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
      mmax_q <= mmax;
    end
  end

  // S6: leading one position of the largest magnitude
  logic [LW-1:0] lead;
  always_comb begin
    lead = '0;
    for (int b = 0; b < CMPW; b++) begin
      if (mmax_q[b]) lead = LW'(b);
    end
  end

  logic            s6_vld_q;
  logic [CMPW-1:0] mag6_q [3];
  logic [LW-1:0]   lead_q;
  logic [2:0]      neg6_q;
  logic            zero6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag6_q  <= mag5_q;
      neg6_q  <= neg5_q;
      lead_q  <= lead;
      zero6_q <= (mmax_q == '0);
    end
  end

  // S7: normalize so the largest lands in [2^23, 2^24)
  logic [CMPW-1:0] shifted [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead_q >= pcrd_pkg::NORM_LEAD) begin
        shifted[i] = mag6_q[i] >> (lead_q - pcrd_pkg::NORM_LEAD);
      end else begin
        shifted[i] = mag6_q[i] << (pcrd_pkg::NORM_LEAD - lead_q);
      end
    end
  end

  logic          s7_vld_q;
  logic [MW-1:0] nmag7_q [3];
  logic [2:0]    neg7_q;
  logic          zero7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nmag7_q[i] <= shifted[i][MW-1:0];
      end
      neg7_q  <= neg6_q;
      zero7_q <= zero6_q;
    end
  end

  // S8: squares
  logic          s8_vld_q;
  logic [QW-1:0] sq8_q [3];
  logic [MW-1:0] nmag8_q [3];
  logic [2:0]    neg8_q;
  logic          zero8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq8_q[i] <= QW'(nmag7_q[i]) * QW'(nmag7_q[i]);
      end
      nmag8_q <= nmag7_q;
      neg8_q  <= neg7_q;
      zero8_q <= zero7_q;
    end
  end

  // S9: sum of squares
  logic             s9_vld_q;
  logic [SSW-1:0]   ssq9_q;
  logic [SIDEW-1:0] side9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else if (en) begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ssq9_q  <= SSW'(sq8_q[0]) + SSW'(sq8_q[1]) + SSW'(sq8_q[2]);
      side9_q <= {zero8_q, neg8_q, nmag8_q[2], nmag8_q[1], nmag8_q[0]};
    end
  end

  // vector length
  logic             sqrt_vld;
  logic [RW-1:0]    root;
  logic [SIDEW-1:0] sqrt_side;

  pcrd_sqrt #(
    .R_W    (RW),
    .SIDE_W (SIDEW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s9_vld_q),
    .rad_i   (ssq9_q),
    .side_i  (side9_q),
    .valid_o (sqrt_vld),
    .root_o  (root),
    .side_o  (sqrt_side)
  );

  // S10: (mag << 15) + n/2 over n
  logic [RW-1:0] n_eff;
  assign n_eff = (root == '0) ? RW'(1) : root;

  logic                s10_vld_q;
  logic [2:0][NNW-1:0] nnum_q;
  logic [2:0][RW-1:0]  nden_q;
  logic [3:0]          side10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_vld_q <= 1'b0;
    end else if (en) begin
      s10_vld_q <= sqrt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nnum_q[i] <= (NNW'(sqrt_side[i*MW +: MW]) << pcrd_pkg::OUT_FRAC)
                     + NNW'(n_eff >> 1);
        nden_q[i] <= n_eff;
      end
      side10_q <= sqrt_side[SIDEW-1 -: 4];
    end
  end

  logic               ndiv_vld;
  logic [2:0][NQW-1:0] ndiv_quo;

  pcrd_div #(
    .LANES (3),
    .NUM_W (NNW),
    .DEN_W (RW),
    .QUO_W (NQW)
  ) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s10_vld_q),
    .num_i   (nnum_q),
    .den_i   (nden_q),
    .valid_o (ndiv_vld),
    .quo_o   (ndiv_quo)
  );

  // signs and zero flag ride alongside the divider
  logic [3:0] side_dl_q [NQW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dl_q[0] <= side10_q;
      for (int i = 1; i < NQW; i++) begin
        side_dl_q[i] <= side_dl_q[i-1];
      end
    end
  end

  assign v_last = ndiv_vld;

  // clamp and apply sign
  logic [3:0]           side_last;
  logic [2:0][OW-1:0]   dir;
  logic [NQW-1:0]       qc;
  pcrd_pkg::ray_out_t   res;

  assign side_last = side_dl_q[NQW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_last[i]) begin
        qc     = (ndiv_quo[i] > NQW'(32768)) ? NQW'(32768) : ndiv_quo[i];
        dir[i] = OW'(NQW'(0) - qc);
      end else begin
        qc     = (ndiv_quo[i] > NQW'(32767)) ? NQW'(32767) : ndiv_quo[i];
        dir[i] = qc[OW-1:0];
      end
      if (side_last[3]) begin
        dir[i] = '0;
      end
    end
    res.dir_x       = dir[0];
    res.dir_y       = dir[1];
    res.dir_z       = dir[2];
    res.zero_vector = side_last[3];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= v_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/pinhole_camera_ray_direction_top_test.sv =====
// Self-checking testbench for the pinhole camera ray direction block.
module pinhole_camera_ray_direction_top_test;

  localparam int LATENCY = 81;

  class ray_scoreboard;
    logic signed [15:0] corner_x, corner_y, corner_z;
    logic [15:0] span_w, span_h;
    logic [12:0] img_w, img_h;
    pcrd_pkg::ray_out_t pending_rays[$];
    int errors;

    function void reset_regs();
      corner_x = pcrd_pkg::CORNER_X_RST;
      corner_y = pcrd_pkg::CORNER_Y_RST;
      corner_z = pcrd_pkg::CORNER_Z_RST;
      span_w = pcrd_pkg::SPAN_W_RST; span_h = pcrd_pkg::SPAN_H_RST;
      img_w = pcrd_pkg::IMAGE_W_RST; img_h = pcrd_pkg::IMAGE_H_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [pcrd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        pcrd_pkg::REG_CORNER_X: corner_x = val;
        pcrd_pkg::REG_CORNER_Y: corner_y = val;
        pcrd_pkg::REG_CORNER_Z: corner_z = val;
        pcrd_pkg::REG_SPAN_W:   span_w = val;
        pcrd_pkg::REG_SPAN_H:   span_h = val;
        pcrd_pkg::REG_IMAGE_W:  img_w = val[12:0];
        pcrd_pkg::REG_IMAGE_H:  img_h = val[12:0];
        default: ;
      endcase
    endfunction

    function longint span_offset(logic [15:0] span, logic [11:0] p, logic [12:0] sz);
      longint d;
      d = (sz == 0) ? 1 : sz;
      return (longint'(span) * (2 * longint'(p) + 1) + d) / (2 * d);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_pixel(pcrd_pkg::pix_in_t px);
      longint c[3];
      longint unsigned mag[3], m, sum, n, q;
      bit neg[3];
      pcrd_pkg::ray_out_t r;
      c[0] = clamp32(longint'(corner_x) + span_offset(span_w, px.pixel_x, img_w));
      c[1] = clamp32(longint'(corner_y) + span_offset(span_h, px.pixel_y, img_h));
      c[2] = longint'(corner_z);
      m = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = c[i] < 0;
        mag[i] = neg[i] ? -c[i] : c[i];
        if (mag[i] > m) m = mag[i];
      end
      r = '0;
      if (m == 0) begin
        r.zero_vector = 1'b1;
        pending_rays.push_back(r);
        return;
      end
      while (m >= (64'd1 << 24)) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 23)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      n = root_floor(sum);
      if (n == 0) n = 1;
      for (int i = 0; i < 3; i++) begin
        logic [15:0] o;
        q = ((mag[i] << 15) + n / 2) / n;
        if (neg[i]) begin
          if (q > 32768) q = 32768;
          o = 16'(-q);
        end else begin
          if (q > 32767) q = 32767;
          o = 16'(q);
        end
        if (i == 0) r.dir_x = o;
        else if (i == 1) r.dir_y = o;
        else r.dir_z = o;
      end
      pending_rays.push_back(r);
    endfunction

    task check_ray(pcrd_pkg::ray_out_t got);
      pcrd_pkg::ray_out_t exp_ray;
      if (pending_rays.size() == 0) begin
        report_mismatch("result with nothing pending");
        return;
      end
      exp_ray = pending_rays.pop_front();
      if (got.dir_x !== exp_ray.dir_x)
        report_mismatch($sformatf("dir_x %0d exp %0d", got.dir_x, exp_ray.dir_x));
      if (got.dir_y !== exp_ray.dir_y)
        report_mismatch($sformatf("dir_y %0d exp %0d", got.dir_y, exp_ray.dir_y));
      if (got.dir_z !== exp_ray.dir_z)
        report_mismatch($sformatf("dir_z %0d exp %0d", got.dir_z, exp_ray.dir_z));
      if (got.zero_vector !== exp_ray.zero_vector)
        report_mismatch($sformatf("zero_vector %0b exp %0b",
                                  got.zero_vector, exp_ray.zero_vector));
    endtask
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, in_ready_o;
  pcrd_pkg::pix_in_t in_data_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  pcrd_pkg::ray_out_t out_data_o;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [pcrd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pcrd_pkg::CFG_W-1:0] cfg_data_i = '0;

  ray_scoreboard sb = new();
  int hold_off = 0;
  bit stall_random = 1'b0;

  pinhole_camera_ray_direction_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: accept at rising edge, change ready at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_ray(out_data_o);
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else if (stall_random) begin
      out_ready_i <= (gap_len() == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // valid stays up into the next beat unless a gap or a drain drops it
  task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{pixel_x: x, pixel_y: y};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(in_data_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(pcrd_pkg::cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_rays.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic random_camera();
    write_cfg(pcrd_pkg::REG_CORNER_X, 16'($urandom));
    write_cfg(pcrd_pkg::REG_CORNER_Y, 16'($urandom));
    write_cfg(pcrd_pkg::REG_CORNER_Z, 16'($urandom));
    write_cfg(pcrd_pkg::REG_SPAN_W, 16'($urandom));
    write_cfg(pcrd_pkg::REG_SPAN_H, 16'($urandom));
    write_cfg(pcrd_pkg::REG_IMAGE_W, 16'($urandom_range(0, 4096)));
    write_cfg(pcrd_pkg::REG_IMAGE_H, 16'($urandom_range(0, 4096)));
  endtask

  initial begin
    sb.reset_regs();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: corners, center, beyond the image, field extremes
    send_pixel(0, 0, 0);
    send_pixel(639, 479, 0);
    send_pixel(320, 240, 0);
    send_pixel(12'hfff, 12'hfff, 0);
    send_pixel(12'haaa, 12'h555, 0);
    send_pixel(12'h555, 12'haaa, 0);
    wait_drained();

    // zero vector: corners and spans all zero
    write_cfg(pcrd_pkg::REG_CORNER_X, 16'h0000);
    write_cfg(pcrd_pkg::REG_CORNER_Y, 16'h0000);
    write_cfg(pcrd_pkg::REG_CORNER_Z, 16'h0000);
    write_cfg(pcrd_pkg::REG_SPAN_W, 16'h0000);
    write_cfg(pcrd_pkg::REG_SPAN_H, 16'h0000);
    write_cfg(pcrd_pkg::REG_IMAGE_W, 16'h0000);   // zero size acts as one
    write_cfg(pcrd_pkg::REG_IMAGE_H, 16'h1000);
    send_pixel(0, 0, 0);
    send_pixel(12'hfff, 12'hfff, 0);
    wait_drained();

    // extremes of the registers
    write_cfg(pcrd_pkg::REG_CORNER_X, 16'h8000);
    write_cfg(pcrd_pkg::REG_CORNER_Y, 16'h7fff);
    write_cfg(pcrd_pkg::REG_CORNER_Z, 16'h8000);
    write_cfg(pcrd_pkg::REG_SPAN_W, 16'hffff);
    write_cfg(pcrd_pkg::REG_SPAN_H, 16'hffff);
    write_cfg(pcrd_pkg::REG_IMAGE_W, 16'h0001);
    write_cfg(pcrd_pkg::REG_IMAGE_H, 16'h0000);
    send_pixel(0, 0, 0);
    send_pixel(12'hfff, 12'hfff, 0);
    send_pixel(12'hfff, 0, 0);
    send_pixel(0, 12'hfff, 0);
    wait_drained();

    // long receiver stall while pixels keep coming
    hold_off = 300;
    for (int i = 0; i < 120; i++) send_pixel(12'($urandom), 12'($urandom), 0);
    wait_drained();

    stall_random = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      random_camera();
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(0, 3) != 0)
          send_pixel(12'($urandom_range(0, sb.img_w)), 12'($urandom_range(0, sb.img_h)), 1);
        else
          send_pixel(12'($urandom), 12'($urandom), 1);
      end
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending_rays.size() == 0) begin
      $display("pinhole_camera_ray_direction_top_test: PASS");
    end else begin
      $display("pinhole_camera_ray_direction_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("pinhole_camera_ray_direction_top_test: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pcrd_pkg.sv
hw/rtl/pcrd_div.sv
hw/rtl/pcrd_sqrt.sv
hw/rtl/pinhole_camera_ray_direction_top.sv
tb/pinhole_camera_ray_direction_top_test.sv
